### rtl/core/triangle_face_normal_defines.svh
// Assertion macros for the face normal block.
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// Same-cycle implication.
`define TFN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TFN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tfn_pkg.sv
// Shared constants for the face normal pipeline.
package tfn_pkg;
  localparam int Q_FRAC = 14;
  localparam int QW     = Q_FRAC + 1;
  localparam int NORM_W = 16;
endpackage

### rtl/core/tfn_if.sv
// Valid/ready channel interfaces for triangles in and normals out.
interface tfn_in_if #(parameter int COORD_BITS = 12, parameter int INDEX_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
  logic signed [COORD_BITS-1:0] b_x, b_y, b_z;
  logic signed [COORD_BITS-1:0] c_x, c_y, c_z;
  logic [INDEX_BITS-1:0]        index_a, index_b, index_c;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  index_a, index_b, index_c, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                index_a, index_b, index_c, output ready);
endinterface

interface tfn_out_if #(parameter int INDEX_BITS = 16);
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic               degenerate;
  logic [INDEX_BITS-1:0] out_index_a, out_index_b, out_index_c;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                  out_index_a, out_index_b, out_index_c, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
                out_index_a, out_index_b, out_index_c, output ready);
endinterface

### rtl/core/tfn_cross.sv
// Edge vectors, cross product, magnitudes and sum of squares (five stages).
module tfn_cross #(
  parameter int COORD_BITS = 12,
  parameter int SB_W       = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] a_x, a_y, a_z,
  input  logic signed [COORD_BITS-1:0] b_x, b_y, b_z,
  input  logic signed [COORD_BITS-1:0] c_x, c_y, c_z,
  input  logic [SB_W-1:0]              sb_in,
  output logic                         out_valid,
  output logic [2*(2*COORD_BITS+3)+1:0] sum_sq,
  output logic [2:0][2*COORD_BITS+2:0] mag,
  output logic [2:0]                   sgn,
  output logic                         zero,
  output logic [SB_W-1:0]              sb_out
);
  localparam int D  = COORD_BITS + 1;
  localparam int P  = 2 * D;
  localparam int CW = P + 1;
  localparam int SW = 2 * CW + 2;

  logic [4:0]                 v_r;
  logic signed [D-1:0]        u_r [3];
  logic signed [D-1:0]        w_r [3];
  logic signed [P-1:0]        p_r [6];
  logic signed [CW-1:0]       c_r [3];
  logic [2:0][CW-1:0]         m4_r, m5_r;
  logic [2:0][2*CW-1:0]       sq_r;
  logic [2:0]                 s4_r, s5_r;
  logic [SW-1:0]              sum_r;
  logic                       zero_r;
  logic [4:0][SB_W-1:0]       sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0] <= D'(b_x) - D'(a_x);
      u_r[1] <= D'(b_y) - D'(a_y);
      u_r[2] <= D'(b_z) - D'(a_z);
      w_r[0] <= D'(c_x) - D'(a_x);
      w_r[1] <= D'(c_y) - D'(a_y);
      w_r[2] <= D'(c_z) - D'(a_z);
      p_r[0] <= P'(u_r[1]) * P'(w_r[2]);
      p_r[1] <= P'(u_r[2]) * P'(w_r[1]);
      p_r[2] <= P'(u_r[2]) * P'(w_r[0]);
      p_r[3] <= P'(u_r[0]) * P'(w_r[2]);
      p_r[4] <= P'(u_r[0]) * P'(w_r[1]);
      p_r[5] <= P'(u_r[1]) * P'(w_r[0]);
      for (int k = 0; k < 3; k++) begin
        c_r[k] <= CW'(p_r[2*k]) - CW'(p_r[2*k+1]);
      end
      for (int k = 0; k < 3; k++) begin
        m4_r[k] <= c_r[k][CW-1] ? CW'(-c_r[k]) : CW'(c_r[k]);
        s4_r[k] <= c_r[k][CW-1];
        sq_r[k] <= (2*CW)'(c_r[k]) * (2*CW)'(c_r[k]);
      end
      sum_r  <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      zero_r <= (m4_r[0] == '0) && (m4_r[1] == '0) && (m4_r[2] == '0);
      m5_r   <= m4_r;
      s5_r   <= s4_r;
      sb_r   <= {sb_r[3:0], sb_in};
    end
  end

  assign out_valid = v_r[4];
  assign sum_sq    = sum_r;
  assign mag       = m5_r;
  assign sgn       = s5_r;
  assign zero      = zero_r;
  assign sb_out    = sb_r[4];
endmodule

### rtl/core/tfn_sqrt.sv
// Integer square root, one result bit per pipeline stage.
module tfn_sqrt #(
  parameter int RW   = 28,
  parameter int SB_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   s_in,
  input  logic [SB_W-1:0]   sb_in,
  output logic              out_valid,
  output logic [RW-1:0]     root,
  output logic [SB_W-1:0]   sb_out
);
  logic [RW:0]              v;
  logic [RW:0][2*RW-1:0]    s_a;
  logic [RW:0][RW+1:0]      rem_a;
  logic [RW:0][RW-1:0]      root_a;
  logic [RW:0][SB_W-1:0]    sb_a;

  assign v[0]      = in_valid;
  assign s_a[0]    = s_in;
  assign rem_a[0]  = '0;
  assign root_a[0] = '0;
  assign sb_a[0]   = sb_in;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [RW+3:0] sh, trial;
    logic          ge;
    assign sh    = {rem_a[i], s_a[i][2*RW-1 -: 2]};
    assign trial = {2'b00, root_a[i], 2'b01};
    assign ge    = sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[i+1]  <= ge ? (RW+2)'(sh - trial) : (RW+2)'(sh);
        root_a[i+1] <= {root_a[i][RW-2:0], ge};
        s_a[i+1]    <= {s_a[i][2*RW-3:0], 2'b00};
        sb_a[i+1]   <= sb_a[i];
      end
    end
  end

  assign out_valid = v[RW];
  assign root      = root_a[RW];
  assign sb_out    = sb_a[RW];
endmodule

### rtl/core/tfn_div.sv
// Restoring divide of three magnitudes by the root, one quotient bit per stage.
module tfn_div
  import tfn_pkg::*;
#(
  parameter int RW   = 28,
  parameter int CW   = 27,
  parameter int SB_W = 52
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [RW-1:0]        divisor,
  input  logic [2:0][CW-1:0]   mag,
  input  logic [SB_W-1:0]      sb_in,
  output logic                 out_valid,
  output logic [2:0][QW-1:0]   quo,
  output logic [SB_W-1:0]      sb_out
);
  logic [QW:0]                   v;
  logic [QW:0][RW-1:0]           d_a;
  logic [QW:0][2:0][RW:0]        rem_a;
  logic [QW:0][2:0][QW-1:0]      q_a;
  logic [QW:0][SB_W-1:0]         sb_a;

  assign v[0]   = in_valid;
  assign d_a[0] = divisor;
  assign q_a[0] = '0;
  assign sb_a[0] = sb_in;
  for (genvar k = 0; k < 3; k++) begin : g_init
    assign rem_a[0][k] = (RW+1)'(mag[k]);
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [2:0][RW:0] sh;
    logic [2:0]       ge;
    for (genvar k = 0; k < 3; k++) begin : g_lane
      if (j == 0) begin : g_first
        assign sh[k] = rem_a[j][k];
      end else begin : g_rest
        assign sh[k] = {rem_a[j][k][RW-1:0], 1'b0};
      end
      assign ge[k] = sh[k] >= {1'b0, d_a[j]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          rem_a[j+1][k] <= ge[k] ? sh[k] - {1'b0, d_a[j]} : sh[k];
          q_a[j+1][k]   <= {q_a[j][k][QW-2:0], ge[k]};
        end
        d_a[j+1]  <= d_a[j];
        sb_a[j+1] <= sb_a[j];
      end
    end
  end

  assign out_valid = v[QW];
  assign quo       = q_a[QW];
  assign sb_out    = sb_a[QW];
endmodule

### rtl/core/triangle_face_normal.sv
// Triangle face normal: cross product normalized to Q1.14, pipelined.
// Pipeline order: cross product, square root, divide, then the output register.
// Throughput: one triangle per cycle; the whole pipe holds while the output stalls.
// Stage count is set by the square root (one root bit per stage) and the divide.
// Reset (synchronous, rst_n low) clears all valid bits; no result is pending after it.
`include "triangle_face_normal_defines.svh"
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int INDEX_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tfn_in_if.sink    in_tri,
  tfn_out_if.source out_norm
);
  localparam int CW = 2 * (COORD_BITS + 1) + 1;
  localparam int RW = CW + 1;

  typedef struct packed {
    logic [2:0][CW-1:0]         mag;
    logic [2:0]                 sgn;
    logic                       zero;
    logic [2:0][INDEX_BITS-1:0] idx;
  } sq_sb_t;

  typedef struct packed {
    logic [2:0]                 sgn;
    logic                       zero;
    logic [2:0][INDEX_BITS-1:0] idx;
  } dv_sb_t;

  logic                       pipe_en;
  logic                       x_valid, s_valid, d_valid;
  logic [2*RW-1:0]            x_sum;
  logic [2:0][CW-1:0]         x_mag;
  logic [2:0]                 x_sgn;
  logic                       x_zero;
  logic [2:0][INDEX_BITS-1:0] x_idx, in_idx;
  sq_sb_t                     s_sb_in, s_sb_out;
  dv_sb_t                     d_sb_in, d_sb_out;
  logic [RW-1:0]              s_root;
  logic [2:0][QW-1:0]         d_quo;
  logic [2:0][NORM_W-1:0]     norm_nxt, norm_r;
  logic                       out_valid_r, degen_r;
  logic [2:0][INDEX_BITS-1:0] idx_r;

  assign pipe_en      = !out_valid_r || out_norm.ready;
  assign in_tri.ready = pipe_en;
  assign in_idx       = {in_tri.index_a, in_tri.index_b, in_tri.index_c};

  tfn_cross #(.COORD_BITS(COORD_BITS), .SB_W(3*INDEX_BITS)) u_cross (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(in_tri.valid),
    .a_x(in_tri.a_x), .a_y(in_tri.a_y), .a_z(in_tri.a_z),
    .b_x(in_tri.b_x), .b_y(in_tri.b_y), .b_z(in_tri.b_z),
    .c_x(in_tri.c_x), .c_y(in_tri.c_y), .c_z(in_tri.c_z),
    .sb_in(in_idx), .out_valid(x_valid), .sum_sq(x_sum), .mag(x_mag),
    .sgn(x_sgn), .zero(x_zero), .sb_out(x_idx)
  );

  assign s_sb_in = '{mag: x_mag, sgn: x_sgn, zero: x_zero, idx: x_idx};

  tfn_sqrt #(.RW(RW), .SB_W($bits(sq_sb_t))) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(x_valid),
    .s_in(x_sum), .sb_in(s_sb_in), .out_valid(s_valid), .root(s_root),
    .sb_out(s_sb_out)
  );

  assign d_sb_in = '{sgn: s_sb_out.sgn, zero: s_sb_out.zero, idx: s_sb_out.idx};

  tfn_div #(.RW(RW), .CW(CW), .SB_W($bits(dv_sb_t))) u_div (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(s_valid),
    .divisor(s_root), .mag(s_sb_out.mag), .sb_in(d_sb_in),
    .out_valid(d_valid), .quo(d_quo), .sb_out(d_sb_out)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (d_sb_out.zero) begin
        norm_nxt[k] = '0;
      end else if (d_sb_out.sgn[k]) begin
        norm_nxt[k] = NORM_W'(-NORM_W'(d_quo[k]));
      end else begin
        norm_nxt[k] = NORM_W'(d_quo[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      norm_r  <= norm_nxt;
      degen_r <= d_sb_out.zero;
      idx_r   <= d_sb_out.idx;
    end
  end

  assign out_norm.valid       = out_valid_r;
  assign out_norm.normal_x    = norm_r[0];
  assign out_norm.normal_y    = norm_r[1];
  assign out_norm.normal_z    = norm_r[2];
  assign out_norm.degenerate  = degen_r;
  assign out_norm.out_index_a = idx_r[2];
  assign out_norm.out_index_b = idx_r[1];
  assign out_norm.out_index_c = idx_r[0];

  `TFN_ASSERT_NOW(a_degen_zero, out_valid_r && degen_r, norm_r == '0, "degenerate normal not zero")
  `TFN_ASSERT_NOW(a_nondegen_nonzero, out_valid_r && !degen_r, norm_r != '0, "normal zero on valid triangle")
  `TFN_ASSERT_NOW(a_range_x, out_valid_r, $signed(norm_r[0]) <= 16384 && $signed(norm_r[0]) >= -16384, "normal_x out of range")
  `TFN_ASSERT_NEXT(a_hold, !pipe_en, $stable(x_valid) && $stable(d_valid), "pipeline moved during stall")
endmodule
